// ===== hw/rtl/mlpb_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpb_pkg
// Shared constants and types of the minute log packet binner.
// ----------------------------------------------------------------------------
package mlpb_pkg;

	localparam int MINUTES_PER_DAY = 1440;
	localparam int VALUE_BITS      = 24;

	localparam int READ_BITS = 24;

	// function codes
	localparam logic [1:0] FN_BYTE   = 2'd0;
	localparam logic [1:0] FN_NOTICE = 2'd1;
	localparam logic [1:0] FN_POINT  = 2'd2;
	localparam logic [1:0] FN_READ   = 2'd3;

	// event codes
	localparam logic [1:0] EV_NOT_READY   = 2'd0;
	localparam logic [1:0] EV_NO_RESPONSE = 2'd1;
	localparam logic [1:0] EV_FAULT       = 2'd2;
	localparam logic [1:0] EV_OK          = 2'd3;

	// machine states
	localparam logic [1:0] ST_OFF  = 2'd0;
	localparam logic [1:0] ST_ON   = 2'd1;
	localparam logic [1:0] ST_WORK = 2'd2;

	// result status codes
	localparam logic [2:0] RS_TAKEN   = 3'd0;
	localparam logic [2:0] RS_STORED  = 3'd1;
	localparam logic [2:0] RS_FAULT   = 3'd2;
	localparam logic [2:0] RS_CLEARED = 3'd3;
	localparam logic [2:0] RS_IGNORED = 3'd4;

	// packet phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_DATA   = 2'd1;
	localparam logic [1:0] PH_IDLE   = 2'd2;

	// configuration register indexes
	localparam logic CFG_OK_CODE      = 1'b0;
	localparam logic CFG_CLEARED_CODE = 1'b1;

	// ceil(2^32 / 60), exact for dividends below 2^22
	localparam logic [26:0] RECIP_60 = 27'd71582789;

	typedef struct packed {
		logic        go;
		logic [15:0] value;
		logic [5:0]  second;
	} split_req_t;

endpackage

// ===== hw/rtl/mlpb_ram.sv =====
// ----------------------------------------------------------------------------
// mlpb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mlpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/mlpb_split.sv =====
// ----------------------------------------------------------------------------
// mlpb_split
// Two-stage unit computing round(v * s / 60) by a reciprocal multiply.
// ----------------------------------------------------------------------------
module mlpb_split
	import mlpb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  split_req_t  req,
	output logic        valid,
	output logic [15:0] cur
);

	logic        vld_s1;
	logic [21:0] x_s1;
	logic        vld_s2;
	logic [15:0] cur_s2;
	logic [48:0] prod;

	assign prod = 49'(x_s1) * 49'(RECIP_60);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.go;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			// plus half of the divisor for rounding
			x_s1 <= 22'(req.value) * 22'(req.second) + 22'd30;
		end
		if (vld_s1) begin
			cur_s2 <= prod[47:32];
		end
	end

	assign valid = vld_s2;
	assign cur   = cur_s2;

endmodule

// ===== hw/rtl/minute_log_packet_binner_core.sv =====
// ----------------------------------------------------------------------------
// minute_log_packet_binner_core
// Per-minute day log fed by controller answer packets, one byte per command.
// ----------------------------------------------------------------------------
// Each command is taken when start is high and busy is low; its single result
// appears on the result ports with done high for one cycle and cannot be held
// off. Notices, header bytes and other packet bytes finish without raising busy;
// a read passes a wait state for the registered table read. A value pair holds
// busy through the split multiplier and the store and add steps on the day table
// RAM, the add step left out at minute zero or an index out of range. A fault
// fill writes one minute per cycle, a time point walks back one minute per pass
// through a read and a check state, and a day rollover clears the whole table
// before its result. After reset the table is cleared with busy high;
// configuration writes are taken at any time.
module minute_log_packet_binner_core
	import mlpb_pkg::*;
#(
	parameter int MINUTES_PER_DAY_P = MINUTES_PER_DAY,
	parameter int VALUE_BITS_P      = VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	input  logic [10:0] minute_of_day,
	input  logic [5:0]  second_of_minute,
	input  logic [23:0] point_value,
	input  logic [1:0]  point_event,
	input  logic [1:0]  point_state,
	output logic        done,
	output logic [2:0]  status,
	output logic        new_day,
	output logic [1:0]  machine_state,
	output logic [READ_BITS-1:0] read_value,
	output logic [1:0]  read_event,
	output logic [1:0]  read_state
);

	localparam int AW = $clog2(MINUTES_PER_DAY_P);
	localparam int VB = VALUE_BITS_P;
	localparam int EW = VB + 4;
	localparam logic [32:0] VMAX = (33'd1 << VB) - 33'd1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_RDWT  = 4'd2;
	localparam logic [3:0] S_WRD   = 4'd3;
	localparam logic [3:0] S_WCHK  = 4'd4;
	localparam logic [3:0] S_FILL  = 4'd5;
	localparam logic [3:0] S_SPLIT = 4'd6;
	localparam logic [3:0] S_STORE = 4'd7;
	localparam logic [3:0] S_ADD   = 4'd8;

	logic [3:0]    state_q;
	logic [7:0]    ok_code_q, clr_code_q;
	logic [10:0]   lrm_q, lm_q, fill_q;
	logic [5:0]    sec_q;
	logic          flag_q, clr_day_q;
	logic [1:0]    ms_q, phase_q;
	logic [7:0]    pos_q, size_q, count_q, low_q;
	logic [AW-1:0] clr_q, walk_q, idx_q;
	logic [15:0]   pair_q;
	logic [6:0]    pnum_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic          accept;
	logic [10:0]   m_clamp;
	logic [5:0]    s_clamp;
	logic [AW-1:0] m_addr;
	logic [VB-1:0] pt_value;
	logic [1:0]    pt_state;
	logic [10:0]   fill_start;
	logic [6:0]    pair_n;
	logic [13:0]   idx_full;
	logic          idx_ok;
	logic          fault;
	logic          split_vld;
	logic [15:0]   split_cur;
	split_req_t    split_req;
	logic [15:0]   rest;
	logic [VB:0]   sum;
	logic [1:0]    cur_st;

	logic [VB-1:0] rd_val;
	logic [1:0]    rd_ev, rd_st;

	assign rd_val = ram_rdata[VB-1:0];
	assign rd_ev  = ram_rdata[VB+1:VB];
	assign rd_st  = ram_rdata[VB+3:VB+2];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign m_clamp = ({2'b00, minute_of_day} > 13'(MINUTES_PER_DAY_P - 1)) ?
		11'(MINUTES_PER_DAY_P - 1) : minute_of_day;
	assign s_clamp = (second_of_minute > 6'd59) ? 6'd59 : second_of_minute;
	assign m_addr  = AW'(m_clamp);

	assign pt_value = ({9'd0, point_value} > VMAX) ? '1 : VB'(point_value);
	assign pt_state = (point_state > ST_WORK) ? ST_WORK : point_state;

	assign fill_start = (lrm_q > lm_q) ? 11'd0 : lrm_q;
	assign fault = ({1'b0, packet_byte, 1'b0} + 10'd5 != {2'b00, size_q}) || flag_q;

	assign pair_n   = 7'((pos_q - 8'd4) >> 1);
	// pair number is held from the transfer, the byte position moves on
	assign idx_full = 14'(lm_q) - 14'(count_q) + 14'(pnum_q) + 14'd1;
	assign idx_ok   = !idx_full[13] && (idx_full < 14'(MINUTES_PER_DAY_P));

	assign split_req.go     = accept && (func == FN_BYTE) && (pos_q != 8'd0) &&
		(phase_q == PH_DATA) && (pos_q >= 8'd4) && pos_q[0] &&
		({1'b0, pair_n} < count_q);
	assign split_req.value  = {packet_byte, low_q};
	assign split_req.second = sec_q;

	mlpb_split u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (split_req),
		.valid  (split_vld),
		.cur    (split_cur)
	);

	assign rest   = pair_q - split_cur;
	assign sum    = {1'b0, rd_val} + (VB + 1)'(rest);
	assign cur_st = (split_cur == 16'd0) ? ST_ON : ST_WORK;

	mlpb_ram #(
		.WIDTH (EW),
		.DEPTH (MINUTES_PER_DAY_P)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = m_addr;
		unique case (state_q)
			S_IDLE: begin
				if (accept && func == FN_POINT) begin
					ram_we    = 1'b1;
					ram_waddr = m_addr;
					ram_wdata = {pt_state, point_event, pt_value};
				end
			end
			S_CLR: begin
				ram_we = 1'b1;
			end
			S_WRD: begin
				ram_raddr = walk_q - AW'(1);
			end
			S_WCHK: begin
				ram_waddr = walk_q;
				ram_wdata = {rd_st, EV_NO_RESPONSE, rd_val};
				ram_we    = (rd_ev == EV_NOT_READY);
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(fill_q);
				ram_wdata = {ST_OFF, EV_FAULT, VB'(0)};
			end
			S_STORE: begin
				ram_we    = idx_ok;
				ram_waddr = AW'(idx_full);
				ram_wdata = {cur_st, EV_OK, VB'(split_cur)};
				ram_raddr = AW'(idx_full) - AW'(1);
			end
			S_ADD: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = {rd_st, rd_ev, sum[VB] ? {VB{1'b1}} : sum[VB-1:0]};
				ram_raddr = idx_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			clr_day_q  <= 1'b0;
			ok_code_q  <= 8'd0;
			clr_code_q <= 8'd1;
			lrm_q      <= '0;
			flag_q     <= 1'b0;
			ms_q       <= ST_OFF;
			pos_q      <= '0;
			size_q     <= '0;
			count_q    <= '0;
			low_q      <= '0;
			lm_q       <= '0;
			sec_q      <= '0;
			phase_q    <= PH_HEADER;
			walk_q     <= '0;
			fill_q     <= '0;
			idx_q      <= '0;
			pair_q     <= '0;
			pnum_q     <= '0;
			done       <= 1'b0;
			status     <= RS_TAKEN;
			new_day    <= 1'b0;
			read_value <= '0;
			read_event <= '0;
			read_state <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_OK_CODE) begin
					ok_code_q <= cfg_data;
				end else begin
					clr_code_q <= cfg_data;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status     <= RS_TAKEN;
						new_day    <= 1'b0;
						read_value <= '0;
						read_event <= '0;
						read_state <= '0;
						case (func)
							FN_NOTICE: begin
								flag_q <= 1'b1;
								done   <= 1'b1;
							end
							FN_POINT: begin
								walk_q <= m_addr;
								if (m_addr == '0) begin
									done <= 1'b1;
								end else begin
									state_q <= S_WRD;
								end
							end
							FN_READ: begin
								state_q <= S_RDWT;
							end
							default: begin
								if (last_byte) begin
									pos_q <= '0;
								end else if (pos_q != 8'hFF) begin
									pos_q <= pos_q + 8'd1;
								end
								done <= 1'b1;
								if (pos_q == 8'd0) begin
									lm_q    <= m_clamp;
									sec_q   <= s_clamp;
									size_q  <= packet_byte;
									count_q <= '0;
									phase_q <= PH_HEADER;
									if (lrm_q > m_clamp) begin
										// day rollover: clear before answering
										done      <= 1'b0;
										clr_q     <= '0;
										clr_day_q <= 1'b1;
										state_q   <= S_CLR;
									end
								end else if (phase_q == PH_HEADER && pos_q == 8'd2) begin
									if (packet_byte == ok_code_q) begin
										status <= RS_TAKEN;
									end else if (packet_byte == clr_code_q) begin
										lrm_q   <= lm_q;
										phase_q <= PH_IDLE;
										status  <= RS_CLEARED;
									end else begin
										phase_q <= PH_IDLE;
										status  <= RS_IGNORED;
									end
								end else if (phase_q == PH_HEADER && pos_q == 8'd3) begin
									count_q <= packet_byte;
									if (fault) begin
										flag_q  <= 1'b0;
										phase_q <= PH_IDLE;
										status  <= RS_FAULT;
										fill_q  <= fill_start;
										if (fill_start < lm_q) begin
											done    <= 1'b0;
											state_q <= S_FILL;
										end
									end else begin
										phase_q <= PH_DATA;
									end
								end else if (phase_q == PH_DATA && pos_q >= 8'd4) begin
									if (!pos_q[0]) begin
										low_q <= packet_byte;
									end else if (split_req.go) begin
										pair_q  <= {packet_byte, low_q};
										pnum_q  <= pair_n;
										status  <= RS_STORED;
										done    <= 1'b0;
										state_q <= S_SPLIT;
									end
								end
							end
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MINUTES_PER_DAY_P - 1)) begin
						state_q <= S_IDLE;
						if (clr_day_q) begin
							done    <= 1'b1;
							new_day <= 1'b1;
						end
						clr_day_q <= 1'b0;
					end
				end
				S_RDWT: begin
					read_value <= READ_BITS'(rd_val);
					read_event <= rd_ev;
					read_state <= rd_st;
					done       <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_WRD: begin
					walk_q  <= walk_q - AW'(1);
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					// walk stops at the first entry already filled in, or at minute zero
					if (rd_ev != EV_NOT_READY || walk_q == '0) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_FILL: begin
					ms_q   <= ST_OFF;
					fill_q <= fill_q + 11'd1;
					if (fill_q + 11'd1 == lm_q) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SPLIT: begin
					if (split_vld) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					idx_q <= AW'(idx_full) - AW'(1);
					if (idx_ok) begin
						ms_q <= cur_st;
					end
					if (!idx_ok || idx_full == 14'd0) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign machine_state = ms_q;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the minute log packet binner: directed packets,
// notices, time points and reads, then random traffic, also under other
// configured codes, all checked against a behavioral model of the day table.
// ----------------------------------------------------------------------------
module testbench
	import mlpb_pkg::*;
;

	localparam int CYCLE_LIMIT = 20000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [7:0]  packet_byte;
	logic        last_byte;
	logic [10:0] minute_of_day;
	logic [5:0]  second_of_minute;
	logic [23:0] point_value;
	logic [1:0]  point_event;
	logic [1:0]  point_state;
	logic        done;
	logic [2:0]  status;
	logic        new_day;
	logic [1:0]  machine_state;
	logic [23:0] read_value;
	logic [1:0]  read_event;
	logic [1:0]  read_state;

	minute_log_packet_binner_core dut (.*);

	typedef struct packed {
		logic [2:0]  status;
		logic        new_day;
		logic [1:0]  machine_state;
		logic [23:0] read_value;
		logic [1:0]  read_event;
		logic [1:0]  read_state;
	} outcome_t;

	outcome_t expected_q[$];
	int       error_count;
	int       cycle_count;

	// model state
	logic [23:0] day_value[MINUTES_PER_DAY];
	logic [1:0]  day_event[MINUTES_PER_DAY];
	logic [1:0]  day_state[MINUTES_PER_DAY];
	logic [7:0]  ok_code, cleared_code;
	int          last_req_min;
	bit          not_cleared;
	logic [1:0]  cur_state;
	int          byte_pos;
	int          pkt_size, pkt_count;
	logic [7:0]  low_hold;
	int          lat_min, lat_sec;
	logic [1:0]  phase;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	always @(posedge clk) begin
		outcome_t got, exp;
		if (arst_n && done) begin
			got = '{status, new_day, machine_state, read_value, read_event, read_state};
			if (expected_q.size() == 0) begin
				report("result with nothing expected");
			end else begin
				exp = expected_q.pop_front();
				if (got.status !== exp.status)
					report($sformatf("status %0d exp %0d", got.status, exp.status));
				if (got.new_day !== exp.new_day)
					report($sformatf("new_day %0d exp %0d", got.new_day, exp.new_day));
				if (got.machine_state !== exp.machine_state)
					report($sformatf("machine_state %0d exp %0d", got.machine_state,
						exp.machine_state));
				if (got.read_value !== exp.read_value)
					report($sformatf("read_value %0h exp %0h", got.read_value,
						exp.read_value));
				if (got.read_event !== exp.read_event)
					report($sformatf("read_event %0d exp %0d", got.read_event,
						exp.read_event));
				if (got.read_state !== exp.read_state)
					report($sformatf("read_state %0d exp %0d", got.read_state,
						exp.read_state));
			end
		end
	end

	function automatic void clear_day();
		for (int i = 0; i < MINUTES_PER_DAY; i++) begin
			day_value[i] = '0;
			day_event[i] = EV_NOT_READY;
			day_state[i] = ST_OFF;
		end
	endfunction

	function automatic int clamp_min(input logic [10:0] m);
		return (m > 11'(MINUTES_PER_DAY - 1)) ? MINUTES_PER_DAY - 1 : int'(m);
	endfunction

	function automatic void bin_pair(input int n, input int v);
		int cur, rest, idx;
		longint sum;
		cur = (v * lat_sec * 2 + 60) / 120;
		rest = v - cur;
		idx = lat_min - pkt_count + 1 + n;
		if (idx < 0 || idx >= MINUTES_PER_DAY)
			return;
		day_value[idx] = 24'(cur);
		day_event[idx] = EV_OK;
		day_state[idx] = (cur == 0) ? ST_ON : ST_WORK;
		cur_state = day_state[idx];
		if (idx == 0)
			return;
		sum = longint'(day_value[idx-1]) + longint'(rest);
		if (sum > 64'hFFFFFF)
			sum = 64'hFFFFFF;
		day_value[idx-1] = sum[23:0];
	endfunction

	function automatic outcome_t predict_outcome(input logic [1:0] f, input logic [7:0] b,
			input logic lb, input logic [10:0] mn, input logic [5:0] sc,
			input logic [23:0] pv, input logic [1:0] pe, input logic [1:0] ps);
		outcome_t r;
		int m, fs;
		r = '0;
		case (f)
			FN_BYTE: begin
				if (byte_pos == 0) begin
					lat_min = clamp_min(mn);
					lat_sec = (sc > 6'd59) ? 59 : int'(sc);
					pkt_size = int'(b);
					pkt_count = 0;
					phase = PH_HEADER;
					if (last_req_min > lat_min) begin
						clear_day();
						r.new_day = 1'b1;
					end
				end else if (phase == PH_HEADER && byte_pos == 2) begin
					if (b == ok_code) begin
						r.status = RS_TAKEN;
					end else if (b == cleared_code) begin
						last_req_min = lat_min;
						phase = PH_IDLE;
						r.status = RS_CLEARED;
					end else begin
						phase = PH_IDLE;
						r.status = RS_IGNORED;
					end
				end else if (phase == PH_HEADER && byte_pos == 3) begin
					pkt_count = int'(b);
					if (int'(b) * 2 != pkt_size - 5 || not_cleared) begin
						fs = (last_req_min > lat_min) ? 0 : last_req_min;
						for (m = fs; m < lat_min; m++) begin
							day_value[m] = '0;
							day_event[m] = EV_FAULT;
							day_state[m] = ST_OFF;
							cur_state = ST_OFF;
						end
						not_cleared = 0;
						phase = PH_IDLE;
						r.status = RS_FAULT;
					end else begin
						phase = PH_DATA;
					end
				end else if (phase == PH_DATA && byte_pos >= 4) begin
					if (((byte_pos - 4) & 1) == 0) begin
						low_hold = b;
					end else if (((byte_pos - 4) >> 1) < pkt_count) begin
						bin_pair((byte_pos - 4) >> 1, int'({b, low_hold}));
						r.status = RS_STORED;
					end
				end
				if (byte_pos < 255)
					byte_pos++;
				if (lb)
					byte_pos = 0;
			end
			FN_NOTICE: not_cleared = 1;
			FN_POINT: begin
				m = clamp_min(mn);
				day_value[m] = pv;
				day_event[m] = pe;
				day_state[m] = (ps > ST_WORK) ? ST_WORK : ps;
				// walk back over minutes never reported
				while (m > 0) begin
					m--;
					if (day_event[m] != EV_NOT_READY)
						break;
					day_event[m] = EV_NO_RESPONSE;
				end
			end
			default: begin
				m = clamp_min(mn);
				r.read_value = day_value[m];
				r.read_event = day_event[m];
				r.read_state = day_state[m];
			end
		endcase
		r.machine_state = cur_state;
		return r;
	endfunction

	int burst_left;

	// one transfer, with bursts and random gaps on the sending side
	task automatic send_item(input logic [1:0] f, input logic [7:0] b, input logic lb,
			input logic [10:0] mn, input logic [5:0] sc, input logic [23:0] pv,
			input logic [1:0] pe, input logic [1:0] ps);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		func <= f;
		packet_byte <= b;
		last_byte <= lb;
		minute_of_day <= mn;
		second_of_minute <= sc;
		point_value <= pv;
		point_event <= pe;
		point_state <= ps;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_q.push_back(predict_outcome(f, b, lb, mn, sc, pv, pe, ps));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lb, input logic [10:0] mn,
			input logic [5:0] sc);
		send_item(FN_BYTE, b, lb, mn, sc, 24'($urandom), 2'($urandom), 2'($urandom));
	endtask

	task automatic send_point(input logic [10:0] mn, input logic [23:0] pv,
			input logic [1:0] pe, input logic [1:0] ps);
		send_item(FN_POINT, 8'($urandom), 1'($urandom), mn, 6'($urandom), pv, pe, ps);
	endtask

	task automatic send_read(input logic [10:0] mn);
		send_item(FN_READ, 8'($urandom), 1'($urandom), mn, 6'($urandom), 24'($urandom),
			2'($urandom), 2'($urandom));
	endtask

	// whole packet: size, spare, code, count, then value pairs and extra bytes
	task automatic send_packet(input logic [7:0] code, input int count, input int size,
			input int extra, input logic [10:0] mn, input logic [5:0] sc);
		int nb;
		nb = 4 + 2 * count + extra;
		for (int i = 0; i < nb; i++) begin
			logic [7:0] b;
			case (i)
				0: b = 8'(size);
				2: b = code;
				3: b = 8'(count);
				default: b = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
			endcase
			send_byte(b, i == nb - 1, mn, sc);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		// rollover clear or a long walk can still be running
		repeat (3 * MINUTES_PER_DAY) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_OK_CODE)
			ok_code = val;
		else
			cleared_code = val;
	endtask

	task automatic test_directed();
		send_read(11'd0);
		send_read(11'h7FF);
		send_packet(ok_code, 2, 9, 0, 11'd10, 6'd0);
		send_packet(ok_code, 2, 9, 3, 11'd20, 6'd59);
		send_packet(ok_code, 3, 11, 0, 11'd1, 6'd63);
		send_read(11'd0);
		send_read(11'd19);
		send_packet(ok_code, 2, 7, 0, 11'd30, 6'd30);
		send_packet(cleared_code, 0, 0, 2, 11'd40, 6'd5);
		send_packet(8'd77, 0, 0, 1, 11'd41, 6'd5);
		send_item(FN_NOTICE, 8'd0, 1'b0, 11'd0, 6'd0, 24'd0, EV_NOT_READY, ST_OFF);
		send_packet(ok_code, 1, 7, 0, 11'd45, 6'd10);
		send_point(11'h7FF, 24'hFFFFFF, EV_OK, 2'd3);
		send_point(11'd100, 24'd5, EV_NOT_READY, ST_ON);
		send_read(11'd60);
		send_read(11'd1439);
		send_packet(ok_code, 1, 7, 0, 11'd5, 6'd20);
		send_read(11'd45);
	endtask

	task automatic test_random(input int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			int sel, cnt, ext;
			logic [10:0] mn;
			sel = $urandom_range(0, 99);
			mn = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 120));
			if (sel < 45) begin
				cnt = $urandom_range(0, 4);
				ext = $urandom_range(0, 2);
				send_packet(($urandom_range(0, 4) == 0) ? cleared_code : ok_code, cnt,
					($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 255)) : 5 + 2 * cnt,
					ext, mn, 6'($urandom));
				sent += 4 + 2 * cnt + ext;
			end else if (sel < 55) begin
				send_byte(8'($urandom), 1'($urandom), mn, 6'($urandom));
				sent++;
			end else if (sel < 62) begin
				send_item(FN_NOTICE, 8'($urandom), 1'($urandom), 11'($urandom), 6'($urandom),
					24'($urandom), 2'($urandom), 2'($urandom));
				sent++;
			end else if (sel < 78) begin
				send_point(mn, 24'($urandom), 2'($urandom), 2'($urandom));
				sent++;
			end else begin
				send_read(mn);
				sent++;
			end
		end
	endtask

	task automatic test_codes();
		write_cfg(CFG_OK_CODE, 8'hFF);
		write_cfg(CFG_CLEARED_CODE, 8'h00);
		test_random(300);
		drain();
		write_cfg(CFG_OK_CODE, 8'h5A);
		write_cfg(CFG_CLEARED_CODE, 8'h5A);
		test_random(150);
		drain();
		write_cfg(CFG_OK_CODE, 8'h00);
		write_cfg(CFG_CLEARED_CODE, 8'hFF);
		test_random(300);
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		func = FN_BYTE;
		packet_byte = '0;
		last_byte = 1'b0;
		minute_of_day = '0;
		second_of_minute = '0;
		point_value = '0;
		point_event = EV_NOT_READY;
		point_state = ST_OFF;
		clear_day();
		ok_code = 8'd0;
		cleared_code = 8'd1;
		last_req_min = 0;
		not_cleared = 0;
		cur_state = ST_OFF;
		byte_pos = 0;
		pkt_size = 0;
		pkt_count = 0;
		low_hold = '0;
		lat_min = 0;
		lat_sec = 0;
		phase = PH_HEADER;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(550);
		drain();
		test_codes();
		drain();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mlpb_pkg.sv
hw/rtl/mlpb_ram.sv
hw/rtl/mlpb_split.sv
hw/rtl/minute_log_packet_binner_core.sv
test/testbench.sv
